FILE: src/mqe_pkg.sv
package mqe_pkg;

	localparam int NumEqs = 128;
	localparam int VecWords = 4;
	localparam int ProductBlocks = 65;
	localparam int EqStride = 262;
	localparam int StoreDepth = NumEqs * EqStride;
	localparam int AddrW = $clog2(StoreDepth);
	localparam int EqW = $clog2(NumEqs);

	typedef enum logic [2:0] {
		ACT_LOAD_C = 3'd0,
		ACT_LOAD_X = 3'd1,
		ACT_LOAD_Y = 3'd2,
		ACT_EVAL   = 3'd3,
		ACT_POLAR  = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_EQ,
		ST_OUT
	} state_t;

	// rotate each byte left by s
	function automatic logic [63:0] byte_rot(input logic [63:0] w, input logic [1:0] s);
		logic [63:0] r;
		logic [15:0] v;
		for (int i = 0; i < 8; i++) begin
			v = {w[8*i +: 8], w[8*i +: 8]} << s;
			r[8*i +: 8] = v[15:8];
		end
		return r;
	endfunction

	// rotate 128-bit (w1:w0) left by d
	function automatic logic [127:0] rot128(input logic [127:0] v, input logic [6:0] d);
		logic [255:0] t;
		t = {v, v} << d;
		return t[255:128];
	endfunction

	function automatic logic [255:0] rot_copy(input logic [255:0] v, input logic [6:0] blk);
		logic [255:0] r;
		logic [6:0] sh;
		logic [6:0] rel;
		r = v;
		rel = blk - 7'd8;
		sh = '0;
		if (blk == 7'd64) begin
			r = {64'd0, v[255:192], 64'd0, v[127:64]};
		end else begin
			if (blk < 7'd8) begin
				sh = {blk[3:0], 3'd0};
			end else if (blk < 7'd56) begin
				for (int h = 0; h < 4; h++)
					r[64*h +: 64] = byte_rot(v[64*h +: 64], rel[5:4] + 2'd1);
				sh = {rel[3:0], 3'd0};
			end else begin
				sh = {blk[3:0] - 4'd8, 3'd4};
			end
			r = {rot128(r[255:128], sh), rot128(r[127:0], sh)};
		end
		return r;
	endfunction

	function automatic logic [255:0] gf4_mul(input logic [255:0] a, input logic [255:0] b);
		logic [127:0] al, ah, bl, bh;
		al = a[127:0]; ah = a[255:128];
		bl = b[127:0]; bh = b[255:128];
		return {(ah & bl) ^ (al & bh) ^ (ah & bh), (al & bl) ^ (ah & bh)};
	endfunction

endpackage

FILE: src/mqe_ram.sv
module mqe_ram #(
	parameter int Width = 64,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: src/mq_system_eval_gf4_core.sv
// Quadratic system evaluator over GF(4), bitsliced, 128 variables.
// Input channel (in_valid/in_stall): action, word_index, word_data.
//   Load actions (coefficient, x, y word) write one word each.
//   Evaluate actions (plain, polar) build 65 product vectors into a product
//   RAM, one 64-bit word per cycle, then walk every equation: for each one
//   the coefficient RAM is read one 64-bit word per cycle (262 reads in
//   plain mode, 258 in polar mode), then the read pipe drains; each word is
//   multiplied against the matching x or product word and folded into a
//   running parity pair. in_stall is high for the whole evaluation.
// Output channel (out_valid/out_stall): four result words, index 0..3,
//   one per cycle without stalls, last_word on the fourth. A stalled word
//   is held; the block stays busy until all four are taken.
// Reset (arst_n low) clears x, y, results and control; coefficient and
//   product RAMs are not cleared and must be written before use.
module mq_system_eval_gf4_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [15:0] word_index,
	input  logic [63:0] word_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_word,
	output logic [1:0]  result_index,
	output logic        last_word
);
	localparam int PW = $clog2(mqe_pkg::ProductBlocks * 4);

	mqe_pkg::state_t state_q, state_d;
	logic [255:0] x_q, y_q;
	logic [255:0] res_q;
	logic polar_q;
	logic [6:0] blk_q;
	logic [mqe_pkg::EqW-1:0] eq_q;
	logic [8:0] wcnt_q;
	logic rd_s1;
	logic [8:0] wcnt_s1;
	logic [1:0] par_q;
	logic [1:0] oidx_q;
	logic [mqe_pkg::AddrW-1:0] base_q;

	logic accept;
	logic c_we;
	logic [mqe_pkg::AddrW-1:0] c_raddr;
	logic [63:0] c_rdata;
	logic p_we;
	logic [PW-1:0] p_waddr, p_raddr;
	logic [255:0] prod;
	logic [63:0] p_rdata;
	logic [PW-1:0] p_wsel;
	logic [255:0] res_flip;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != mqe_pkg::ST_IDLE);
	assign out_valid = (state_q == mqe_pkg::ST_OUT);
	assign result_word = res_q[64*oidx_q +: 64];
	assign result_index = oidx_q;
	assign last_word = (oidx_q == 2'd3);

	assign c_we = accept && (action == mqe_pkg::ACT_LOAD_C)
		&& (word_index < 16'(mqe_pkg::StoreDepth));

	mqe_ram #(.Width(64), .Depth(mqe_pkg::StoreDepth)) u_coeff (
		.clk(clk), .we(c_we), .waddr(word_index[mqe_pkg::AddrW-1:0]),
		.wdata(word_data), .raddr(c_raddr), .rdata(c_rdata));

	// product of block blk_q, written as four words, one per lane of wcnt_q[1:0]
	always_comb begin
		logic [255:0] xr, yr;
		xr = mqe_pkg::rot_copy(x_q, blk_q);
		yr = mqe_pkg::rot_copy(y_q, blk_q);
		if (polar_q) prod = mqe_pkg::gf4_mul(x_q, yr) ^ mqe_pkg::gf4_mul(y_q, xr);
		else prod = mqe_pkg::gf4_mul(x_q, xr);
	end

	// product RAM holds 64-bit words; word w of block b at 4b+w
	// one block per cycle would need a 256-bit port, so use wcnt_q[1:0] as word lane
	assign p_we = (state_q == mqe_pkg::ST_PROD);
	assign p_wsel = PW'({blk_q, wcnt_q[1:0]});
	assign p_waddr = p_wsel;

	mqe_ram #(.Width(64), .Depth(mqe_pkg::ProductBlocks * 4)) u_prod (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(prod[64*wcnt_q[1:0] +: 64]),
		.raddr(p_raddr), .rdata(p_rdata));

	// word n of an equation: 0..3 linear, 4..259 blocks 0..63, 260/261 block 64
	always_comb begin
		c_raddr = base_q + mqe_pkg::AddrW'(wcnt_q);
		if (wcnt_q < 9'd4) p_raddr = '0;
		else if (wcnt_q == 9'd260) p_raddr = PW'(256);
		else if (wcnt_q == 9'd261) p_raddr = PW'(258);
		else p_raddr = PW'(wcnt_q - 9'd4);
	end

	// GF(4) multiply-accumulate on one word pair; partner plane comes from x/product
	// low words 0 and 1 are held per lane, then combined with high words 2 and 3
	logic [127:0] lo_c_q, lo_p_q;
	logic [63:0] a_word, xw;
	logic [63:0] lo_c, lo_p;
	logic [1:0] lane;
	logic is_lin, is_b64, lsel, fold;
	always_comb begin
		lane = wcnt_s1[1:0];
		is_lin = wcnt_s1 < 9'd4;
		is_b64 = wcnt_s1 >= 9'd260;
		xw = x_q[64*lane +: 64];
		a_word = is_lin ? xw : p_rdata;
		// block 64 has only lane 0: low at 260, high at 261
		lsel = wcnt_s1[0] && !is_b64;
		lo_c = lo_c_q[64*lsel +: 64];
		lo_p = lo_p_q[64*lsel +: 64];
		fold = rd_s1 && ((wcnt_s1[1] && !is_b64) || (wcnt_s1 == 9'd261));
	end

	logic [63:0] t_lo, t_hi;
	always_comb begin
		t_lo = (lo_p & lo_c) ^ (a_word & c_rdata);
		t_hi = (a_word & lo_c) ^ (lo_p & c_rdata) ^ (a_word & c_rdata);
	end

	// parity bits of the finished equation at their result positions
	assign res_flip = 256'({par_q[1], 127'd0, par_q[0]}) << 7'(eq_q);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mqe_pkg::ST_IDLE:
				if (accept && (action == mqe_pkg::ACT_EVAL || action == mqe_pkg::ACT_POLAR))
					state_d = mqe_pkg::ST_PROD;
			mqe_pkg::ST_PROD:
				if (blk_q == 7'd64 && wcnt_q[1:0] == 2'd3) state_d = mqe_pkg::ST_EQ;
			mqe_pkg::ST_EQ:
				if (eq_q == mqe_pkg::EqW'(mqe_pkg::NumEqs - 1) && wcnt_q == 9'd263)
					state_d = mqe_pkg::ST_OUT;
			mqe_pkg::ST_OUT:
				if (!out_stall && oidx_q == 2'd3) state_d = mqe_pkg::ST_IDLE;
			default: state_d = mqe_pkg::ST_IDLE;
		endcase
	end

	// vectors, counters and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mqe_pkg::ST_IDLE;
			x_q <= '0; y_q <= '0; res_q <= '0;
			polar_q <= 1'b0; blk_q <= '0; eq_q <= '0; wcnt_q <= '0;
			wcnt_s1 <= '0; rd_s1 <= 1'b0; par_q <= '0; oidx_q <= '0; base_q <= '0;
			lo_c_q <= '0; lo_p_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				mqe_pkg::ST_IDLE: begin
					if (accept && word_index < 16'd4) begin
						if (action == mqe_pkg::ACT_LOAD_X) x_q[64*word_index[1:0] +: 64] <= word_data;
						if (action == mqe_pkg::ACT_LOAD_Y) y_q[64*word_index[1:0] +: 64] <= word_data;
					end
					if (state_d == mqe_pkg::ST_PROD) begin
						polar_q <= (action == mqe_pkg::ACT_POLAR);
						blk_q <= '0; wcnt_q <= '0; res_q <= '0;
					end
				end
				mqe_pkg::ST_PROD: begin
					// skip the linear words in polar mode
					if (state_d == mqe_pkg::ST_EQ) begin
						wcnt_q <= polar_q ? 9'd4 : 9'd0;
					end else if (wcnt_q[1:0] == 2'd3) begin
						blk_q <= blk_q + 7'd1;
						wcnt_q <= '0;
					end else begin
						wcnt_q <= wcnt_q + 9'd1;
					end
					eq_q <= '0; base_q <= '0; par_q <= '0;
					rd_s1 <= 1'b0;
				end
				mqe_pkg::ST_EQ: begin
					// issue reads for words up to 261, then let the last one settle
					rd_s1 <= wcnt_q < 9'd262;
					wcnt_s1 <= wcnt_q;
					if (rd_s1 && !wcnt_s1[1]) begin
						lo_c_q[64*wcnt_s1[0] +: 64] <= c_rdata;
						lo_p_q[64*wcnt_s1[0] +: 64] <= a_word;
					end
					if (wcnt_q == 9'd263) begin
						res_q <= res_q ^ res_flip;
						par_q <= '0;
						eq_q <= eq_q + 1'b1;
						base_q <= base_q + mqe_pkg::AddrW'(mqe_pkg::EqStride);
						wcnt_q <= polar_q ? 9'd4 : 9'd0;
					end else begin
						wcnt_q <= wcnt_q + 9'd1;
						if (fold) par_q <= par_q ^ {^t_hi, ^t_lo};
					end
					oidx_q <= '0;
				end
				mqe_pkg::ST_OUT:
					if (!out_stall) oidx_q <= oidx_q + 2'd1;
				default: ;
			endcase
		end
	end

	// the block never takes input while results are pending
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("input taken during output");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(result_index)))
		else $error("stalled result moved");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_word) |=> !out_valid)
		else $error("extra result after last word");
endmodule
